// File: rtl/okxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okxd_pkg: shared types and helpers for the offset keyed XOR descrambler
// Holds the pipeline stage record, register indexes and keystream arithmetic.
// ----------------------------------------------------------------------------
package okxd_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;

  // Register indexes on the configuration port.
  localparam logic REG_KEY_WORD    = 1'b0;
  localparam logic REG_BASE_OFFSET = 1'b1;

  // Keystream constants.
  localparam logic [BYTE_W-1:0] HEADER_MULT = 8'hEA;
  localparam logic [BYTE_W-1:0] DATA_ADD_A  = 8'd3;
  localparam logic [BYTE_W-1:0] DATA_ADD_B  = 8'd1;
  localparam logic [BYTE_W-1:0] HDR_ADD_A   = 8'd1;
  localparam logic [BYTE_W-1:0] HDR_ADD_B   = 8'd2;

  // One pipeline stage worth of item state.
  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
    logic [BYTE_W-1:0] pos_lo;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] dvd;
    logic [BYTE_W-1:0] quo;
    logic [BYTE_W-1:0] ks;
  } stage_t;

  // One restoring division step: brings in the next dividend bit and keeps
  // only the low eight quotient bits.
  function automatic stage_t div_step(stage_t s, logic [WORD_W-1:0] divisor);
    stage_t        r;
    logic [WORD_W:0] shifted;
    logic [WORD_W:0] diff;
    r       = s;
    shifted = {s.rem, s.dvd[WORD_W-1]};
    diff    = shifted - {1'b0, divisor};
    if (!diff[WORD_W]) begin
      r.rem = diff[WORD_W-1:0];
      r.quo = {s.quo[BYTE_W-2:0], 1'b1};
    end else begin
      r.rem = shifted[WORD_W-1:0];
      r.quo = {s.quo[BYTE_W-2:0], 1'b0};
    end
    r.dvd = {s.dvd[WORD_W-2:0], 1'b0};
    return r;
  endfunction

  // First half of the data keystream: (q+3)(q+1)+h, modulo 256.
  function automatic logic [BYTE_W-1:0] data_pre(logic [BYTE_W-1:0] q,
                                                 logic [BYTE_W-1:0] h);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [2*BYTE_W-1:0] prod;
    a    = q + DATA_ADD_A;
    b    = q + DATA_ADD_B;
    prod = a * b;
    return prod[BYTE_W-1:0] + h;
  endfunction

  // First half of the header keystream: (p+1)^2+p+2, modulo 256.
  function automatic logic [BYTE_W-1:0] hdr_pre(logic [BYTE_W-1:0] p);
    logic [BYTE_W-1:0] a;
    logic [2*BYTE_W-1:0] prod;
    a    = p + HDR_ADD_A;
    prod = a * a;
    return prod[BYTE_W-1:0] + p + HDR_ADD_B;
  endfunction

  // Low byte of an 8 by 8 product.
  function automatic logic [BYTE_W-1:0] mul_lo(logic [BYTE_W-1:0] a,
                                               logic [BYTE_W-1:0] b);
    logic [2*BYTE_W-1:0] prod;
    prod = a * b;
    return prod[BYTE_W-1:0];
  endfunction

endpackage

// File: rtl/offset_keyed_xor_descrambler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_keyed_xor_descrambler_top: position keyed archive byte descrambler
// XORs each byte with a keystream taken from its position, either through a
// pipelined division by the key word or from a fixed header sequence.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_stall   | cmd, data_in, byte_position, last_in
//  output   | out_valid / out_stall | data_out, last_out, key_error
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction is accepted per clock cycle while in_stall is low; each
// produces exactly one output transaction. The pipeline consists of the
// 32-stage restoring divider (one quotient bit per stage) plus an input
// stage, two keystream stages and the output register.
// Reset (rst, synchronous, active high) empties the pipeline and loads the
// key word with 1 and the base offset with 0.
// While the output is stalled the pipeline keeps moving and closes its gaps
// until a transaction reaches the last stage; that transaction is parked in a
// skid register and the whole pipeline freezes from the next cycle on, so
// in_stall is a registered signal and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module offset_keyed_xor_descrambler_top
  import okxd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input transactions.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [7:0]        data_in,
  input  logic [31:0]       byte_position,
  input  logic              last_in,
  // Output transactions.
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_out,
  output logic              last_out,
  output logic              key_error,
  // Configuration writes.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  // Stage 0 captures the input, stages 1 to 32 each resolve one quotient bit,
  // stage 33 forms the keystream pre-product and stage 34 the final byte.
  localparam int unsigned DIV_STAGES = WORD_W;
  localparam int unsigned K1_STAGE   = DIV_STAGES + 1;
  localparam int unsigned K2_STAGE   = DIV_STAGES + 2;
  localparam int unsigned NSTAGE     = DIV_STAGES + 3;

  logic [WORD_W-1:0] key_word;
  logic [WORD_W-1:0] base_offset;

  stage_t            stage      [NSTAGE];
  stage_t            stage_next [NSTAGE];
  logic [NSTAGE-1:0] stage_vld;
  logic              advance;

  stage_t            skid;
  logic              skid_valid;

  logic [BYTE_W-1:0] key_h;

  // The user must write the configuration registers only while the block is
  // idle (the block itself does not enforce it), so every stage may read them directly.
  assign cfg_ready = 1'b1;
  assign key_h     = key_word[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word    <= 32'd1;
      base_offset <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_WORD:    key_word    <= cfg_data;
        REG_BASE_OFFSET: base_offset <= cfg_data;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the skid register is free.
  assign advance  = !skid_valid;
  assign in_stall = skid_valid;

  always_comb begin
    // Input stage: relative position and the zero key check.
    stage_next[0]        = '0;
    stage_next[0].cmd    = cmd;
    stage_next[0].data   = data_in;
    stage_next[0].last   = last_in;
    stage_next[0].err    = !cmd && (key_word == '0);
    stage_next[0].pos_lo = byte_position[BYTE_W-1:0];
    stage_next[0].dvd    = byte_position - base_offset;

    // Divider stages, one quotient bit each.
    for (int i = 1; i <= DIV_STAGES; i++) begin
      stage_next[i] = div_step(stage[i-1], key_word);
    end

    // Keystream, first multiplication.
    stage_next[K1_STAGE] = stage[K1_STAGE-1];
    if (stage[K1_STAGE-1].cmd) begin
      stage_next[K1_STAGE].ks = hdr_pre(stage[K1_STAGE-1].pos_lo);
    end else begin
      stage_next[K1_STAGE].ks = data_pre(stage[K1_STAGE-1].quo, key_h);
    end

    // Keystream, second multiplication and the XOR. A zero key in data mode
    // passes the byte through untouched.
    stage_next[K2_STAGE] = stage[K2_STAGE-1];
    if (stage[K2_STAGE-1].cmd) begin
      stage_next[K2_STAGE].data = stage[K2_STAGE-1].data
                                ^ mul_lo(stage[K2_STAGE-1].ks, HEADER_MULT);
    end else if (!stage[K2_STAGE-1].err) begin
      stage_next[K2_STAGE].data = stage[K2_STAGE-1].data
                                ^ mul_lo(stage[K2_STAGE-1].ks, key_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else if (advance) begin
      stage_vld <= {stage_vld[NSTAGE-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NSTAGE; i++) begin
        stage[i] <= stage_next[i];
      end
    end
  end

  // Output register with a skid register behind it. While the skid register
  // holds a transaction the pipeline is frozen, so the last stage keeps its
  // contents until it can move on.
  stage_t out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= stage_vld[NSTAGE-1];
      end
    end else if (stage_vld[NSTAGE-1] && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else begin
        out_reg <= stage[NSTAGE-1];
      end
    end else if (!skid_valid) begin
      skid <= stage[NSTAGE-1];
    end
  end

  assign data_out  = out_reg.data;
  assign last_out  = out_reg.last;
  assign key_error = out_reg.err;

  // A parked transaction always has one in front of it at the output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a transaction with the output empty");

  // While a transaction is parked the last pipeline stage does not move.
  a_frozen_tail: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> (stage_vld[NSTAGE-1] == $past(stage_vld[NSTAGE-1])))
    else $error("pipeline moved while the skid register was occupied");

  // When the output drains, a parked transaction takes its place next cycle.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && !out_stall) |=> (out_valid && !skid_valid))
    else $error("parked transaction not moved to the output");

endmodule

// File: tb/sv/okxd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okxd_checker: result checker for the offset keyed XOR descrambler
// Watches the configuration, input and output channels, keeps its own copy of
// the key word and base offset, predicts every descrambled byte and compares
// the output stream against the predictions in order.
// ----------------------------------------------------------------------------
module okxd_checker
  import okxd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  data_in,
  input  logic [31:0] byte_position,
  input  logic        last_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  data_out,
  input  logic        last_out,
  input  logic        key_error,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          outstanding,
  output int          fails,
  output int          checked,
  output int          header_seen,
  output int          key_errors
);

  localparam logic [7:0] HDR_SCALE = 8'hEA;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       key_err;
  } plain_byte_t;

  logic [31:0] key_shadow  = 32'd1;
  logic [31:0] base_shadow = 32'd0;
  plain_byte_t plain_fifo[$];
  int          miss_n   = 0;
  int          check_n  = 0;
  int          hdr_n    = 0;
  int          keyerr_n = 0;

  // All sums and products below are taken in an 8-bit context, so they wrap
  // modulo 256 exactly as the keystream requires.
  function automatic plain_byte_t descramble(logic is_header, logic [7:0] din,
                                             logic [31:0] pos, logic lst);
    plain_byte_t r;
    logic [7:0]  p;
    logic [7:0]  a;
    logic [7:0]  q;
    logic [7:0]  h;
    logic [7:0]  ks;
    logic [31:0] rel;
    r.last    = lst;
    r.key_err = 1'b0;
    if (is_header) begin
      p      = pos[7:0];
      a      = p + 8'd1;
      ks     = (a * a + p + 8'd2) * HDR_SCALE;
      r.data = din ^ ks;
    end else if (key_shadow == 32'd0) begin
      r.data    = din;
      r.key_err = 1'b1;
    end else begin
      rel    = byte_position_rel(pos);
      q      = 8'(rel / key_shadow);
      h      = key_shadow[15:8];
      ks     = ((q + 8'd3) * (q + 8'd1) + h) * h;
      r.data = din ^ ks;
    end
    return r;
  endfunction

  function automatic logic [31:0] byte_position_rel(logic [31:0] pos);
    return pos - base_shadow;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns  MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    miss_n++;
  endtask

  always @(posedge clk) begin : watch
    plain_byte_t want;
    if (rst) begin
      key_shadow  = 32'd1;
      base_shadow = 32'd0;
      plain_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_WORD) begin
          key_shadow = cfg_data;
        end else begin
          base_shadow = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        if (plain_fifo.size() == 0) begin
          flag_mismatch("output with nothing pending, data_out", 32'(data_out), 'x);
        end else begin
          want = plain_fifo.pop_front();
          check_n++;
          if (data_out !== want.data) begin
            flag_mismatch("data_out", 32'(data_out), 32'(want.data));
          end
          if (last_out !== want.last) begin
            flag_mismatch("last_out", 32'(last_out), 32'(want.last));
          end
          if (key_error !== want.key_err) begin
            flag_mismatch("key_error", 32'(key_error), 32'(want.key_err));
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = descramble(cmd, data_in, byte_position, last_in);
        if (cmd) hdr_n++;
        if (want.key_err) keyerr_n++;
        plain_fifo.push_back(want);
      end
    end
    outstanding <= plain_fifo.size();
    fails       <= miss_n;
    checked     <= check_n;
    header_seen <= hdr_n;
    key_errors  <= keyerr_n;
  end

endmodule

// File: tb/sv/tb_offset_keyed_xor_descrambler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_offset_keyed_xor_descrambler_top: testbench for the XOR descrambler
// Drives directed and random byte transactions through several key word and
// base offset settings with random idling on both channels; a separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_offset_keyed_xor_descrambler_top
  import okxd_pkg::*;
();

  // Meaning of the cmd field.
  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_HEADER = 1'b1;

  localparam int     ITEMS_PER_PHASE = 100;
  localparam int     PHASES          = 7;
  localparam int     HOLD_CYCLES     = 200;
  // The final drain allows a good margin over the pipeline depth.
  localparam int     DRAIN_CYCLES    = 64;
  localparam longint LIMIT_NS        = 5_000_000;

  logic        clk;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        cmd           = CMD_DATA;
  logic [7:0]  data_in       = 8'h00;
  logic [31:0] byte_position = 32'h0;
  logic        last_in       = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [7:0]  data_out;
  logic        last_out;
  logic        key_error;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = REG_KEY_WORD;
  logic [31:0] cfg_data      = 32'h0;

  int outstanding;
  int fails;
  int checked;
  int header_seen;
  int key_errors;

  // Requests from the stimulus process to the output side. A change of
  // hold_asks asks the receiver for one long hold-off; rx_calm stops its
  // random stalls altogether.
  int   hold_asks = 0;
  logic rx_calm   = 1'b0;

  // Stimulus-side view of the current settings, used only to aim positions
  // at interesting quotients; prediction lives entirely in the checker.
  logic [31:0] cur_key  = 32'd1;
  logic [31:0] cur_base = 32'd0;
  bit          tx_calm  = 1'b0;
  int          settings = 1;

  offset_keyed_xor_descrambler_top dut (.*);
  okxd_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a transaction.
  initial begin
    #(LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Idle length for either side: mostly nothing, sometimes a few cycles and
  // now and then a long stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output side. The long hold-off is counted here, in its own process, so
  // that the sender can keep offering transactions while the pipeline fills
  // and the block raises in_stall.
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_len() + 1) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Presents one byte transaction and returns on the edge at which it is
  // accepted. in_valid is left high so that a following transaction can go
  // out back to back without a second assignment in the same step.
  task automatic offer_byte(logic c, logic [7:0] d, logic [31:0] p, logic l);
    in_valid      <= 1'b1;
    cmd           <= c;
    data_in       <= d;
    byte_position <= p;
    last_in       <= l;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_tx(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every predicted byte has come back. The
  // first edge lets the checker count the transaction accepted last.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes both registers back to back; only called with the block idle.
  task automatic set_regs(logic [31:0] key, logic [31:0] base);
    cfg_valid <= 1'b1;
    cfg_index <= REG_KEY_WORD;
    cfg_data  <= key;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BASE_OFFSET;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_key  = key;
    cur_base = base;
    settings++;
  endtask

  // Positions are a mix of fully random values, values just around quotient
  // boundaries above the base offset, values below the base offset (so the
  // relative position wraps) and values at the very top and bottom.
  function automatic logic [31:0] random_position();
    logic [31:0] stride;
    stride = cur_key * 32'($urandom_range(0, 300));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return cur_base + stride + 32'($urandom_range(0, 3));
      7:          return cur_base + stride - 32'd1;
      8:          return cur_base - 32'($urandom_range(1, 1000));
      default:    return {($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000,
                          8'($urandom())};
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] k;
    logic [31:0] b;
    logic        c;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. First the reset settings (key word 1, base offset 0):
    // header bytes across the whole position range and data bytes at the
    // extremes of every field.
    offer_byte(CMD_HEADER, 8'h00, 32'h0000_0000, 1'b0);
    offer_byte(CMD_HEADER, 8'hFF, 32'h0000_00FF, 1'b1);
    offer_byte(CMD_HEADER, 8'hA5, 32'hFFFF_FFFF, 1'b0);
    offer_byte(CMD_HEADER, 8'h5A, 32'h1234_5680, 1'b0);
    offer_byte(CMD_DATA,   8'h00, 32'h0000_0000, 1'b0);
    offer_byte(CMD_DATA,   8'hFF, 32'hFFFF_FFFF, 1'b1);
    offer_byte(CMD_DATA,   8'h3C, 32'h0000_0100, 1'b0);
    wait_idle();

    // A zero key word: data bytes pass unchanged with the error flag set,
    // while header bytes are descrambled as usual with no error.
    set_regs(32'h0000_0000, 32'h0000_0020);
    offer_byte(CMD_DATA,   8'h81, 32'h0000_0040, 1'b0);
    offer_byte(CMD_HEADER, 8'h81, 32'h0000_0040, 1'b0);
    offer_byte(CMD_DATA,   8'hFF, 32'h0000_0000, 1'b1);
    wait_idle();

    // Largest key word and base offset: relative positions wrap around.
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_byte(CMD_DATA, 8'h11, 32'h0000_0000, 1'b0);
    offer_byte(CMD_DATA, 8'h22, 32'hFFFF_FFFE, 1'b0);
    offer_byte(CMD_DATA, 8'h33, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // A mid-range key: positions below the base offset and either side of a
    // quotient step.
    set_regs(32'h0000_AB03, 32'h0001_0000);
    offer_byte(CMD_DATA,   8'hFF, 32'h0000_FFFF, 1'b0);
    offer_byte(CMD_DATA,   8'h00, 32'h0000_0000, 1'b0);
    offer_byte(CMD_DATA,   8'h96, 32'h0001_0000 + 32'h0000_AB03 * 5, 1'b0);
    offer_byte(CMD_DATA,   8'h69, 32'h0001_0000 + 32'h0000_AB03 * 5 - 1, 1'b1);
    offer_byte(CMD_HEADER, 8'hC3, 32'h0000_0080, 1'b0);
    wait_idle();

    // Random part, one phase per register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          k = 32'($urandom_range(1, 8));
          b = 32'h0;
        end
        1: begin
          k = {16'h0, 8'($urandom()), 8'($urandom())} | 32'h0000_0100;
          b = $urandom();
        end
        2: begin
          k = 32'hFFFF_FFFF;
          b = 32'hFFFF_FFFF;
        end
        3: begin
          k = 32'h0;
          b = $urandom();
        end
        4: begin
          k = $urandom();
          b = $urandom();
        end
        5: begin
          k = {16'h0, 8'($urandom()), 8'($urandom_range(1, 255))};
          b = $urandom();
        end
        default: begin
          k = 32'($urandom_range(1, 32'h0001_FFFF));
          b = 32'h0;
        end
      endcase
      set_regs(k, b);

      // Phase 1 asks the receiver for a long hold-off while the sender
      // keeps offering back to back, so the pipeline fills and stalls the
      // input. Phase 5 runs with no idling on either side.
      tx_calm = (ph == 1) || (ph == 5);
      rx_calm <= (ph == 5);
      if (ph == 1) hold_asks <= hold_asks + 1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Half way through phase 4 the sender stops until every result
        // has come back, then carries on.
        if (ph == 4 && n == ITEMS_PER_PHASE / 2) wait_idle();
        c = ($urandom_range(0, 3) == 0) ? CMD_HEADER : CMD_DATA;
        offer_byte(c, 8'($urandom()), random_position(), $urandom_range(0, 7) == 0);
        pause_tx(tx_calm ? 0 : idle_len());
      end
      wait_idle();
    end

    // Let any stray output show up before the verdict.
    rx_calm <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d descrambled bytes (%0d header, %0d zero-key) over %0d settings.",
             checked, header_seen, key_errors, settings);
    $display("Random idling on both sides, a %0d-cycle output hold-off and a mid-stream drain.",
             HOLD_CYCLES);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
